/* hdl/swk_pkg.sv */
// shared types and constants of the sub-block walker
// used by swk_step and subblock_tlv_walker; depends on nothing

package swk_pkg;

    // width of the saturating message byte counter
    localparam int OFFSET_BITS = 16;

    // header sizes in bytes
    localparam logic [15:0] HDR_SIZE_SHORT = 16'd2;
    localparam logic [15:0] HDR_SIZE_LONG  = 16'd4;

    // output data width, packed fields padded to whole bytes
    localparam int OUT_DATA_BITS = 80;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_HEADER   = 2'd0;
    localparam logic [1:0] CFG_HEADER_OFFSET = 2'd1;
    localparam logic [1:0] CFG_COUNT_FROM_MSG = 2'd2;
    localparam logic [1:0] CFG_PRESET_COUNT  = 2'd3;

    // byte role codes on the output
    localparam logic [1:0] ROLE_PREFIX  = 2'd0;
    localparam logic [1:0] ROLE_HEADER  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_AFTER   = 2'd3;

    // walk phase
    typedef enum logic [3:0] {
        PH_PREFIX  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_AFTER   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        long_header;
        logic [7:0]  header_offset;
        logic        count_from_message;
        logic [15:0] preset_count;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [OFFSET_BITS-1:0] msg_offset;
        logic [15:0]            remaining;
        logic [15:0]            index;
        logic [15:0]            ident;
        logic [15:0]            length;
        logic [15:0]            position;
    } walk_state_t;

    localparam walk_state_t WALK_RESET = '{
        phase:      PH_PREFIX,
        msg_offset: '0,
        remaining:  16'd0,
        index:      16'd0,
        ident:      16'd0,
        length:     16'd0,
        position:   16'd0
    };

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_role;
        logic [15:0] block_number;
        logic [15:0] block_ident;
        logic [15:0] block_length;
        logic [15:0] offset_in_block;
        logic        block_end;
        logic        message_end;
        logic        overrun_error;
    } result_t;

endpackage

/* hdl/swk_in_stage.sv */
// input register of the sub-block walker: holds one incoming word
// depends on nothing but the handshake from the consuming stage

module swk_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte[7:0]
    input  logic       s_tlast,     // last_in_message
    input  logic       take,        // consumer takes the held word this cycle
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // room whenever empty or the held word leaves now
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

/* hdl/swk_step.sv */
// one step of the walk: next walk state and tagged result for one byte
// depends on swk_pkg for the state, config and result types

module swk_step
(
    input  swk_pkg::cfg_t        cfg,
    input  swk_pkg::walk_state_t cur,
    input  logic [7:0]           din,
    input  logic                 last,
    output swk_pkg::walk_state_t nxt,
    output swk_pkg::result_t     res
);

    always_comb
    begin
        swk_pkg::walk_state_t st;
        logic [15:0] hs;
        logic [16:0] p_inc;
        logic        done;
        logic        bend;
        logic        in_block;
        logic        advance;

        st       = cur;
        done     = 1'b0;
        bend     = 1'b0;
        in_block = 1'b0;
        advance  = 1'b0;
        hs       = cfg.long_header ? swk_pkg::HDR_SIZE_LONG : swk_pkg::HDR_SIZE_SHORT;

        res                 = '0;
        res.byte_out        = din;
        res.byte_role       = swk_pkg::ROLE_PREFIX;
        res.message_end     = last;

        // prefix: latch count byte or move on to the first block, or past the blocks when the count is zero
        if (st.phase == swk_pkg::PH_PREFIX)
        begin
            if (st.msg_offset < swk_pkg::OFFSET_BITS'(cfg.header_offset))
            begin
                if (cfg.count_from_message)
                begin
                    st.remaining = {8'd0, din};
                end
            end
            else
            begin
                if (!cfg.count_from_message)
                begin
                    st.remaining = cfg.preset_count;
                end
                else if (cfg.header_offset == 8'd0)
                begin
                    st.remaining = 16'd0;
                end
                st.ident    = 16'd0;
                st.length   = 16'd0;
                st.position = 16'd0;
                st.phase    = (st.remaining == 16'd0) ? swk_pkg::PH_AFTER
                                                      : swk_pkg::PH_HEADER;
            end
        end

        p_inc = {1'b0, st.position} + 17'd1;

        case (st.phase)
            swk_pkg::PH_HEADER:
            begin
                res.byte_role       = swk_pkg::ROLE_HEADER;
                res.block_number    = st.index;
                res.offset_in_block = st.position;
                in_block            = 1'b1;
                // header byte meaning from its position
                if (cfg.long_header)
                begin
                    if (st.position == 16'd0)
                    begin
                        st.ident = {din, 8'd0};
                    end
                    else if (st.position == 16'd1)
                    begin
                        st.ident = st.ident | {8'd0, din};
                    end
                    else if (st.position == 16'd2)
                    begin
                        st.length = {din, 8'd0};
                    end
                    else
                    begin
                        st.length = st.length | {8'd0, din};
                        done      = 1'b1;
                    end
                end
                else
                begin
                    if (st.position == 16'd0)
                    begin
                        st.ident = {8'd0, din};
                    end
                    else
                    begin
                        st.length = {8'd0, din};
                        done      = 1'b1;
                    end
                end
                if (done)
                begin
                    if (st.length < hs)
                    begin
                        st.length = hs;
                    end
                    res.block_ident  = st.ident;
                    res.block_length = st.length;
                    if ({1'b0, st.length} <= p_inc)
                    begin
                        bend    = 1'b1;
                        advance = 1'b1;
                    end
                    else
                    begin
                        st.position = p_inc[15:0];
                        st.phase    = swk_pkg::PH_PAYLOAD;
                    end
                end
                else
                begin
                    st.position = p_inc[15:0];
                end
            end
            swk_pkg::PH_PAYLOAD:
            begin
                res.byte_role       = swk_pkg::ROLE_PAYLOAD;
                res.block_number    = st.index;
                res.offset_in_block = st.position;
                res.block_ident     = st.ident;
                res.block_length    = st.length;
                in_block            = 1'b1;
                if (p_inc >= {1'b0, st.length})
                begin
                    bend    = 1'b1;
                    advance = 1'b1;
                end
                else
                begin
                    st.position = p_inc[15:0];
                end
            end
            swk_pkg::PH_AFTER:
            begin
                res.byte_role    = swk_pkg::ROLE_AFTER;
                res.block_number = st.index;
            end
            default:
            begin
                res.byte_role = swk_pkg::ROLE_PREFIX;
            end
        endcase

        // step to the next block
        if (advance)
        begin
            st.remaining = st.remaining - 16'd1;
            st.index     = st.index + 16'd1;
            st.ident     = 16'd0;
            st.length    = 16'd0;
            st.position  = 16'd0;
            st.phase     = (st.remaining == 16'd0) ? swk_pkg::PH_AFTER
                                                   : swk_pkg::PH_HEADER;
        end

        // saturating message byte count
        if (st.msg_offset != '1)
        begin
            st.msg_offset = st.msg_offset + swk_pkg::OFFSET_BITS'(1);
        end

        res.block_end     = bend;
        res.overrun_error = last && in_block && !bend;

        // message end restarts the walk
        if (last)
        begin
            st = swk_pkg::WALK_RESET;
        end

        nxt = st;
    end

endmodule

/* hdl/subblock_tlv_walker.sv */
// top level of the sub-block walker: config registers, walk state, result register
// depends on swk_pkg, swk_in_stage and swk_step

// Tags every byte of a message with its role in a type-length-value walk:
// prefix, block header, block payload or after the last block, together
// with block number, id, length, offset in the block and block-end and
// overrun flags. One byte goes in and one tagged word comes out per clock
// while m_tready is high; each byte passes the input register and then the
// result register, and the walk state is updated in the same cycle the
// result is registered. The sustained rate is one byte per cycle without
// back-pressure, as the walk state is updated with each result. Write the
// configuration only while no bytes are in flight; a message end returns
// the walk to the prefix of the next message.

module subblock_tlv_walker
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic        s_tlast,    // last_in_message
    // tagged word output
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_out[7:0], block_number[23:8], block_ident[39:24], block_length[55:40],
    // offset_in_block[71:56], block_end[72], overrun_error[73], zeros[79:74]
    output logic [swk_pkg::OUT_DATA_BITS-1:0] m_tdata,
    output logic [1:0]  m_tuser,    // byte_role[1:0]
    output logic        m_tlast     // message_end
);

    swk_pkg::cfg_t        cfg_reg;
    swk_pkg::walk_state_t state_reg;
    swk_pkg::walk_state_t state_next;
    swk_pkg::result_t     step_res;
    swk_pkg::result_t     out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 held_valid;
    logic [7:0]           held_byte;
    logic                 held_last;
    logic                 fire;

    // a held byte is processed when the result register is free or its word is taken
    assign fire           = held_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    swk_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    swk_step u_step
    (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .din  (held_byte),
        .last (held_last),
        .nxt  (state_next),
        .res  (step_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_header        <= 1'b0;
            cfg_reg.header_offset      <= 8'd0;
            cfg_reg.count_from_message <= 1'b1;
            cfg_reg.preset_count       <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swk_pkg::CFG_LONG_HEADER:    cfg_reg.long_header        <= cfg_data[0];
                swk_pkg::CFG_HEADER_OFFSET:  cfg_reg.header_offset      <= cfg_data[7:0];
                swk_pkg::CFG_COUNT_FROM_MSG: cfg_reg.count_from_message <= cfg_data[0];
                swk_pkg::CFG_PRESET_COUNT:   cfg_reg.preset_count       <= cfg_data;
                default:                     cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // walk state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swk_pkg::WALK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.overrun_error, out_reg.block_end,
                       out_reg.offset_in_block, out_reg.block_length,
                       out_reg.block_ident, out_reg.block_number, out_reg.byte_out};
    assign m_tuser  = out_reg.byte_role;
    assign m_tlast  = out_reg.message_end;

endmodule
